[src/flw_pkg.sv]
// ----------------------------------------------------------------------------
// flw_pkg
// Shared types, constants and the half-step pattern for the flow drive.
// ----------------------------------------------------------------------------
package flw_pkg;

	localparam int FLOW_WIDTH_DEF   = 16;
	localparam int SETPOINT_WIDTH   = 16;
	localparam int PERIOD_WIDTH     = 8;
	localparam int TIMEOUT_WIDTH    = 24;
	localparam int RUN_WIDTH        = TIMEOUT_WIDTH + 1;
	localparam int PHASE_WIDTH      = 3;
	localparam int COIL_WIDTH       = 4;
	localparam int CFG_INDEX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH   = TIMEOUT_WIDTH;

	localparam logic [SETPOINT_WIDTH-1:0] SETPOINT_RST = 16'd30;
	localparam logic [PERIOD_WIDTH-1:0]   PERIOD_RST   = 8'd10;
	localparam logic [TIMEOUT_WIDTH-1:0]  TIMEOUT_RST  = 24'd180000;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_FLOW_SETPOINT = 2'd0,
		REG_STEP_PERIOD   = 2'd1,
		REG_RUN_TIMEOUT   = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		MODE_HOLD     = 2'd0,
		MODE_DECREASE = 2'd1,
		MODE_INCREASE = 2'd2
	} mode_t;

	typedef struct packed {
		logic [SETPOINT_WIDTH-1:0] flow_setpoint;
		logic [PERIOD_WIDTH-1:0]   step_period;
		logic [TIMEOUT_WIDTH-1:0]  run_timeout;
	} cfg_t;

	typedef struct packed {
		logic [COIL_WIDTH-1:0] coil_pattern;
		logic [1:0]            drive_mode;
		logic                  timed_out;
	} result_t;

	function automatic logic [COIL_WIDTH-1:0] half_step(input logic [PHASE_WIDTH-1:0] ph);
		logic [COIL_WIDTH-1:0] pat;
		case (ph)
			3'd0:    pat = 4'h1;
			3'd1:    pat = 4'h3;
			3'd2:    pat = 4'h2;
			3'd3:    pat = 4'h6;
			3'd4:    pat = 4'h4;
			3'd5:    pat = 4'hC;
			3'd6:    pat = 4'h8;
			3'd7:    pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

endpackage

[src/flw_flow_if.sv]
// ----------------------------------------------------------------------------
// flw_flow_if
// Flow sample channel: valid, ready and one flow value.
// ----------------------------------------------------------------------------
interface flw_flow_if
	import flw_pkg::*;
#(
	parameter int FLOW_WIDTH = FLOW_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic [FLOW_WIDTH-1:0] flow_value;

	modport source (output valid, output flow_value, input ready);
	modport sink   (input valid, input flow_value, output ready);
endinterface

[src/flw_result_if.sv]
// ----------------------------------------------------------------------------
// flw_result_if
// Result channel: valid, ready, coil pattern, drive mode and timeout flag.
// ----------------------------------------------------------------------------
interface flw_result_if
	import flw_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [COIL_WIDTH-1:0] coil_pattern;
	logic [1:0]            drive_mode;
	logic                  timed_out;

	modport source (output valid, output coil_pattern, output drive_mode, output timed_out,
		input ready);
	modport sink   (input valid, input coil_pattern, input drive_mode, input timed_out,
		output ready);
endinterface

[src/flw_cfg_if.sv]
// ----------------------------------------------------------------------------
// flw_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface flw_cfg_if
	import flw_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] index;
	logic [CFG_DATA_WIDTH-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[src/flw_cfg_regs.sv]
// ----------------------------------------------------------------------------
// flw_cfg_regs
// Setpoint, step period and run timeout registers.
// ----------------------------------------------------------------------------
module flw_cfg_regs
	import flw_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
	input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
	output cfg_t                       cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flow_setpoint <= SETPOINT_RST;
			cfg_q.step_period   <= PERIOD_RST;
			cfg_q.run_timeout   <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (cfg_index_t'(wr_index))
				REG_FLOW_SETPOINT: cfg_q.flow_setpoint <= wr_data[SETPOINT_WIDTH-1:0];
				REG_STEP_PERIOD:   cfg_q.step_period   <= wr_data[PERIOD_WIDTH-1:0];
				REG_RUN_TIMEOUT:   cfg_q.run_timeout   <= wr_data[TIMEOUT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[src/flw_ctrl.sv]
// ----------------------------------------------------------------------------
// flw_ctrl
// Deadband mode decision, run timeout, phase divider and coil lookup.
// ----------------------------------------------------------------------------
module flw_ctrl
	import flw_pkg::*;
#(
	parameter int FLOW_WIDTH = FLOW_WIDTH_DEF
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [FLOW_WIDTH-1:0] flow_value,
	input  cfg_t                  cfg,
	output result_t               result
);
	logic [PHASE_WIDTH-1:0]  phase_q;
	logic [PERIOD_WIDTH-1:0] div_q;
	mode_t                   last_mode_q;
	logic [RUN_WIDTH-1:0]    run_q;

	logic [FLOW_WIDTH-1:0] set_w;
	logic [FLOW_WIDTH:0]   flow_ext;
	logic [FLOW_WIDTH:0]   set_ext;
	mode_t                 mode;
	logic [RUN_WIDTH-1:0]  run_base;
	logic [RUN_WIDTH-1:0]  run_sat;
	logic [RUN_WIDTH-1:0]  timeout_ext;
	logic                  tout;
	logic                  adv;
	logic [COIL_WIDTH-1:0] coils;

	always_comb begin
		set_w    = FLOW_WIDTH'(cfg.flow_setpoint);
		flow_ext = {1'b0, flow_value};
		set_ext  = {1'b0, set_w};
		if ((flow_ext + 1'b1) < set_ext)
			mode = MODE_INCREASE;
		else if (flow_ext > (set_ext + 1'b1))
			mode = MODE_DECREASE;
		else
			mode = MODE_HOLD;

		timeout_ext = {1'b0, cfg.run_timeout};
		run_base    = (mode != last_mode_q) ? '0 : run_q;
		tout        = run_base > timeout_ext;
		run_sat     = tout ? timeout_ext : run_base;

		case (mode)
			MODE_DECREASE: coils = half_step(phase_q);
			MODE_INCREASE: coils = half_step(~phase_q);
			default:       coils = '0;
		endcase
		if (tout)
			coils = '0;

		adv = div_q >= cfg.step_period;

		result.coil_pattern = coils;
		result.drive_mode   = mode;
		result.timed_out    = tout;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			div_q       <= '0;
			last_mode_q <= MODE_HOLD;
			run_q       <= '0;
		end else if (step) begin
			phase_q     <= adv ? phase_q + 1'b1 : phase_q;
			div_q       <= adv ? PERIOD_WIDTH'(1) : div_q + 1'b1;
			last_mode_q <= mode;
			run_q       <= run_sat + 1'b1;
		end
	end
endmodule

[src/flow_deadband_halfstep_drive.sv]
// ----------------------------------------------------------------------------
// flow_deadband_halfstep_drive
// Flow-controlled half-step stepper drive with a deadband around the setpoint.
//
//   channel   role    payload
//   flow_in   sink    flow_value
//   result    source  coil_pattern, drive_mode, timed_out
//   cfg       sink    index, data (setpoint, step period, run timeout)
//
// One item per cycle sustained while the result channel is not stalled; an
// accepted flow sample is registered, then mode, counters and coil lookup
// resolve combinationally into the result register.
// arst_n clears the control counters, config to defaults and both valid flags.
// A stalled result holds its item; the input register keeps accepting while
// the result register is free or being drained.
// ----------------------------------------------------------------------------
module flow_deadband_halfstep_drive
	import flw_pkg::*;
#(
	parameter int FLOW_WIDTH = FLOW_WIDTH_DEF
)(
	input  logic                clk,
	input  logic                arst_n,
	flw_flow_if.sink            flow_in,
	flw_result_if.source        result,
	flw_cfg_if.sink             cfg
);
	logic                  valid_s1;
	logic [FLOW_WIDTH-1:0] flow_s1;
	logic                  valid_s2;
	result_t               res_s2;
	logic                  step;
	cfg_t                  cfg_w;
	result_t               res_w;

	assign step          = valid_s1 && (!valid_s2 || result.ready);
	assign flow_in.ready = !valid_s1 || step;
	assign cfg.ready     = 1'b1;

	flw_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_w)
	);

	flw_ctrl #(
		.FLOW_WIDTH (FLOW_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.flow_value (flow_s1),
		.cfg        (cfg_w),
		.result     (res_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (flow_in.ready)
				valid_s1 <= flow_in.valid;
			if (step)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flow_in.valid && flow_in.ready)
			flow_s1 <= flow_in.flow_value;
		if (step)
			res_s2 <= res_w;
	end

	assign result.valid        = valid_s2;
	assign result.coil_pattern = res_s2.coil_pattern;
	assign result.drive_mode   = res_s2.drive_mode;
	assign result.timed_out    = res_s2.timed_out;
endmodule

[src/flw_checker.sv]
// ----------------------------------------------------------------------------
// flw_checker
// Port-level checks for the flow drive, bound to the top level.
// ----------------------------------------------------------------------------
module flw_checker
	import flw_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COIL_WIDTH-1:0] coil_pattern,
	input logic [1:0]            drive_mode,
	input logic                  timed_out
);
	a_tout_coils_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> coil_pattern == '0)
		else $error("coils energized on a timed-out item");

	a_hold_coils_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_mode == MODE_HOLD |-> coil_pattern == '0)
		else $error("coils energized in hold mode");

	a_run_half_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !timed_out && drive_mode != MODE_HOLD
		|-> $countones(coil_pattern) == 1 || $countones(coil_pattern) == 2)
		else $error("coil pattern is not a half-step phase");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled while result side is free");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coil_pattern)
		&& $stable(drive_mode) && $stable(timed_out))
		else $error("stalled result item changed");
endmodule

bind flow_deadband_halfstep_drive flw_checker u_flw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (flow_in.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.coil_pattern (result.coil_pattern),
	.drive_mode   (result.drive_mode),
	.timed_out    (result.timed_out)
);

[verif/flow_deadband_halfstep_drive_chk.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_deadband_halfstep_drive_chk
// Watches the flow, result and register channels of the flow drive. Each
// accepted flow item advances a local copy of the drive state, and the coil
// command that it yields is queued. Each accepted result is compared field by
// field with the oldest queued command. Reports the number of commands still
// outstanding and the number of failures.
// ----------------------------------------------------------------------------
module flow_deadband_halfstep_drive_chk
	import flw_pkg::*;
#(
	parameter int FLOW_WIDTH = FLOW_WIDTH_DEF
)(
	input  logic   clk,
	input  logic   arst_n,
	flw_flow_if    flow_ch,
	flw_result_if  result_ch,
	flw_cfg_if     cfg_ch,
	output int     in_flight,
	output int     mismatches
);

	localparam logic [COIL_WIDTH-1:0] COIL_SEQ [8] = '{
		4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
	};

	logic [SETPOINT_WIDTH-1:0] setpoint;
	logic [PERIOD_WIDTH-1:0]   period;
	logic [TIMEOUT_WIDTH-1:0]  limit;
	logic [PHASE_WIDTH-1:0]    phase;
	logic [PERIOD_WIDTH-1:0]   divider;
	mode_t                     prev_mode;
	logic [RUN_WIDTH-1:0]      run_len;
	result_t                   coil_cmd_q [$];

	function automatic result_t drive_tick(input logic [FLOW_WIDTH-1:0] flow);
		logic [FLOW_WIDTH-1:0] set_w;
		longint                f;
		longint                s;
		mode_t                 m;
		result_t               r;
		set_w = FLOW_WIDTH'(setpoint);
		f = longint'(flow);
		s = longint'(set_w);
		if (f < s - 1)
			m = MODE_INCREASE;
		else if (f > s + 1)
			m = MODE_DECREASE;
		else
			m = MODE_HOLD;
		if (m != prev_mode)
			run_len = '0;
		r.drive_mode   = m;
		r.timed_out    = 1'b0;
		r.coil_pattern = '0;
		if (run_len > {1'b0, limit}) begin
			run_len     = {1'b0, limit};
			r.timed_out = 1'b1;
		end else if (m == MODE_DECREASE) begin
			r.coil_pattern = COIL_SEQ[phase];
		end else if (m == MODE_INCREASE) begin
			r.coil_pattern = COIL_SEQ[3'd7 - phase];
		end
		if (divider >= period) begin
			divider = '0;
			phase   = phase + 1'b1;
		end
		divider   = divider + 1'b1;
		run_len   = run_len + 1'b1;
		prev_mode = m;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			setpoint  = SETPOINT_RST;
			period    = PERIOD_RST;
			limit     = TIMEOUT_RST;
			phase     = '0;
			divider   = '0;
			prev_mode = MODE_HOLD;
			run_len   = '0;
			coil_cmd_q.delete();
			mismatches = 0;
			in_flight <= 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_FLOW_SETPOINT: setpoint = cfg_ch.data[SETPOINT_WIDTH-1:0];
					REG_STEP_PERIOD:   period   = cfg_ch.data[PERIOD_WIDTH-1:0];
					REG_RUN_TIMEOUT:   limit    = cfg_ch.data[TIMEOUT_WIDTH-1:0];
					default: ;
				endcase
			end
			if (flow_ch.valid && flow_ch.ready)
				coil_cmd_q.push_back(drive_tick(flow_ch.flow_value));
			if (result_ch.valid && result_ch.ready) begin
				if (coil_cmd_q.size() == 0) begin
					mismatches++;
					$error("unexpected item: coil_pattern %h drive_mode %0d timed_out %0b",
						result_ch.coil_pattern, result_ch.drive_mode, result_ch.timed_out);
				end else begin
					want = coil_cmd_q.pop_front();
					if (result_ch.coil_pattern !== want.coil_pattern) begin
						mismatches++;
						$error("coil_pattern expected %h actual %h",
							want.coil_pattern, result_ch.coil_pattern);
					end
					if (result_ch.drive_mode !== want.drive_mode) begin
						mismatches++;
						$error("drive_mode expected %0d actual %0d",
							want.drive_mode, result_ch.drive_mode);
					end
					if (result_ch.timed_out !== want.timed_out) begin
						mismatches++;
						$error("timed_out expected %0b actual %0b",
							want.timed_out, result_ch.timed_out);
					end
				end
			end
			in_flight <= coil_cmd_q.size();
		end
	end

endmodule

[verif/flow_deadband_halfstep_drive_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_deadband_halfstep_drive_tb
// Drives flow samples and register writes into the flow drive and stalls its
// result channel at random. A directed opening covers the deadband edges,
// the field extremes, zero and full-scale setpoints, a zero step period, a
// run into the timeout and a timeout lowered in the middle of a run. Random
// blocks follow, each after new register writes, made mostly of runs
// that hold one drive mode with some noise mixed in.
// ----------------------------------------------------------------------------
module flow_deadband_halfstep_drive_tb;
	import flw_pkg::*;

	localparam int FLOW_WIDTH  = FLOW_WIDTH_DEF;
	localparam int BLOCKS      = 13;
	localparam int BLOCK_ITEMS = 98;
	localparam int CALM_BLOCK  = 5;
	localparam int FLOW_TOP    = (1 << FLOW_WIDTH) - 1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

	typedef enum int {
		RUN_HOLD,
		RUN_DECREASE,
		RUN_INCREASE,
		RUN_NOISE
	} run_kind_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   calm;
	int   cur_set;
	int   in_flight;
	int   mismatches;

	flw_flow_if #(.FLOW_WIDTH(FLOW_WIDTH)) flow_ch ();
	flw_result_if                          result_ch ();
	flw_cfg_if                             cfg_ch ();

	flow_deadband_halfstep_drive #(.FLOW_WIDTH(FLOW_WIDTH)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.flow_in (flow_ch),
		.result  (result_ch),
		.cfg     (cfg_ch)
	);

	flow_deadband_halfstep_drive_chk #(.FLOW_WIDTH(FLOW_WIDTH)) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.flow_ch    (flow_ch),
		.result_ch  (result_ch),
		.cfg_ch     (cfg_ch),
		.in_flight  (in_flight),
		.mismatches (mismatches)
	);

	always #5 clk = ~clk;

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= calm || ($urandom_range(99) >= 15);
		end
	end

	task automatic send_flow(input logic [FLOW_WIDTH-1:0] v);
		if (!calm && $urandom_range(99) < 15) begin
			flow_ch.valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		flow_ch.valid      <= 1'b1;
		flow_ch.flow_value <= v;
		do @(posedge clk); while (!flow_ch.ready);
	endtask

	task automatic drain();
		flow_ch.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [CFG_DATA_WIDTH-1:0] val, input bit hold);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (!hold)
			cfg_ch.valid <= 1'b0;
		if (idx == REG_FLOW_SETPOINT)
			cur_set = int'(val[SETPOINT_WIDTH-1:0]);
	endtask

	task automatic program_regs(input logic [SETPOINT_WIDTH-1:0] sp,
		input logic [PERIOD_WIDTH-1:0] per, input logic [TIMEOUT_WIDTH-1:0] lim);
		write_reg(REG_FLOW_SETPOINT, {8'($urandom), sp}, 1'b1);
		write_reg(REG_STEP_PERIOD, {16'($urandom), per}, 1'b1);
		write_reg(REG_RUN_TIMEOUT, lim, 1'b0);
	endtask

	function automatic logic [FLOW_WIDTH-1:0] pick_flow(input run_kind_t kind);
		int lo;
		int hi;
		lo = 0;
		hi = FLOW_TOP;
		case (kind)
			RUN_HOLD: begin
				lo = (cur_set > 0) ? cur_set - 1 : 0;
				hi = (cur_set < FLOW_TOP) ? cur_set + 1 : FLOW_TOP;
			end
			RUN_DECREASE: begin
				if (cur_set + 2 <= FLOW_TOP) begin
					lo = cur_set + 2;
					if ($urandom_range(1))
						hi = (lo + 20 < FLOW_TOP) ? lo + 20 : FLOW_TOP;
				end
			end
			RUN_INCREASE: begin
				if (cur_set >= 2) begin
					hi = cur_set - 2;
					if ($urandom_range(1))
						lo = (hi > 20) ? hi - 20 : 0;
				end
			end
			default: ;
		endcase
		return FLOW_WIDTH'($urandom_range(hi, lo));
	endfunction

	initial begin
		int        sent;
		int        len;
		run_kind_t kind;
		logic [SETPOINT_WIDTH-1:0] sp;
		logic [PERIOD_WIDTH-1:0]   per;
		logic [TIMEOUT_WIDTH-1:0]  lim;

		flow_ch.valid      <= 1'b0;
		flow_ch.flow_value <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= REG_FLOW_SETPOINT;
		cfg_ch.data        <= '0;
		calm               <= 1'b0;
		cur_set = int'(SETPOINT_RST);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// deadband edges around the reset setpoint
		send_flow('0);
		send_flow(16'd28);
		send_flow(16'd29);
		send_flow(16'd30);
		send_flow(16'd31);
		send_flow(16'd32);
		send_flow(FLOW_WIDTH'(FLOW_TOP));
		send_flow(16'd27);

		// zero setpoint, zero period, short timeout
		drain();
		write_reg(REG_UNUSED, 24'hFFFFFF, 1'b1);
		program_regs('0, '0, 24'd3);
		send_flow('0);
		send_flow(16'd1);
		send_flow(16'd2);
		repeat (6) send_flow(FLOW_WIDTH'(FLOW_TOP));
		send_flow(16'hAAAA);

		// full-scale setpoint, period and timeout
		drain();
		program_regs('1, '1, '1);
		send_flow(FLOW_WIDTH'(FLOW_TOP));
		send_flow(FLOW_WIDTH'(FLOW_TOP - 1));
		send_flow(FLOW_WIDTH'(FLOW_TOP - 2));
		repeat (3) send_flow(16'h5555);

		// lower the timeout below the current run length
		drain();
		write_reg(REG_RUN_TIMEOUT, 24'd1, 1'b0);
		send_flow('0);
		send_flow('0);

		for (int b = 0; b < BLOCKS; b++) begin
			drain();
			calm <= (b == CALM_BLOCK);
			if ($urandom_range(3) == 0) begin
				write_reg(REG_RUN_TIMEOUT, TIMEOUT_WIDTH'($urandom_range(3)), 1'b0);
			end else begin
				case ($urandom_range(5))
					0:       sp = '0;
					1:       sp = '1;
					2:       sp = 16'd1;
					3:       sp = 16'hFFFE;
					default: sp = SETPOINT_WIDTH'($urandom);
				endcase
				case ($urandom_range(4))
					0:       per = '0;
					1:       per = '1;
					2, 3:    per = PERIOD_WIDTH'($urandom_range(3));
					default: per = PERIOD_WIDTH'($urandom);
				endcase
				case ($urandom_range(4))
					0:       lim = '0;
					1:       lim = '1;
					default: lim = TIMEOUT_WIDTH'($urandom_range(40));
				endcase
				if ($urandom_range(3) == 0)
					write_reg(REG_UNUSED, CFG_DATA_WIDTH'($urandom), 1'b1);
				program_regs(sp, per, lim);
			end
			sent = 0;
			while (sent < BLOCK_ITEMS) begin
				kind = run_kind_t'($urandom_range(2));
				len  = ($urandom_range(4) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
				for (int i = 0; i < len && sent < BLOCK_ITEMS; i++) begin
					send_flow(pick_flow(($urandom_range(9) == 0) ? RUN_NOISE : kind));
					sent++;
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("flow_deadband_halfstep_drive verification clean");
		else
			$display("flow_deadband_halfstep_drive verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("flow_deadband_halfstep_drive verification failed");
		$finish;
	end

endmodule
